// File: sv/rgb_palette_fader_defines.svh
// ----------------------------------------------------------------------------
// rgb_palette_fader_defines.svh
// Assertion macros shared by the fader modules.
// ----------------------------------------------------------------------------
`ifndef RGB_PALETTE_FADER_DEFINES_SVH
`define RGB_PALETTE_FADER_DEFINES_SVH

// same-cycle implication
`define RPF_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RPF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/rpf_pkg.sv
// ----------------------------------------------------------------------------
// rpf_pkg
// Types, constants and the color table of the palette fader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpf_pkg;

   localparam int RGB_W        = 8;
   localparam int REQ_TYPE_W   = 2;
   localparam int RAND_PICK_W  = 16;
   localparam int RAND_DELAY_W = 5;
   localparam int DELAY_W      = 10;
   localparam int SPEED_W      = 8;
   localparam int DVS_W        = 9;
   localparam int PAL_IDX_W    = 4;
   localparam int DIV_STEPS    = RAND_PICK_W;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

   localparam logic [DIV_CNT_W-1:0]   DIV_LAST    = DIV_CNT_W'(DIV_STEPS - 1);
   localparam logic [RAND_PICK_W-1:0] DELAY_NUM   = RAND_PICK_W'(1000);
   localparam logic [DELAY_W-1:0]     DELAY_RESET = DELAY_W'(1000);

   localparam logic [REQ_TYPE_W-1:0] REQ_TICK  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_START = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_STOP  = 2'd2;

   typedef struct packed {
      logic [RGB_W-1:0] red;
      logic [RGB_W-1:0] green;
      logic [RGB_W-1:0] blue;
   } rgb_type;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_PREP  = 7'b0000010,
      S_CHECK = 7'b0000100,
      S_LOAD  = 7'b0001000,
      S_DIV   = 7'b0010000,
      S_SCAN  = 7'b0100000,
      S_DONE  = 7'b1000000
   } rpf_state_type;

   typedef struct packed {
      logic latch;
      logic prep;
      logic load;
      logic div_step;
      logic scan;
      logic step;
      logic out_load;
   } rpf_cmd_type;

   typedef struct packed {
      logic do_tick;
      logic at_target;
      logic div_last;
      logic scan_hit;
   } rpf_status_type;

   function automatic rgb_type pal_color(input logic [PAL_IDX_W-1:0] idx);
      rgb_type c;
      case (idx)
         4'd0:    c = '{8'd255, 8'd255, 8'd255};
         4'd1:    c = '{8'd255, 8'd0,   8'd0};
         4'd2:    c = '{8'd255, 8'd255, 8'd0};
         4'd3:    c = '{8'd0,   8'd255, 8'd0};
         4'd4:    c = '{8'd0,   8'd0,   8'd255};
         4'd5:    c = '{8'd255, 8'd0,   8'd255};
         4'd6:    c = '{8'd0,   8'd255, 8'd255};
         4'd7:    c = '{8'd128, 8'd0,   8'd0};
         4'd8:    c = '{8'd0,   8'd128, 8'd0};
         4'd9:    c = '{8'd0,   8'd0,   8'd128};
         4'd10:   c = '{8'd128, 8'd128, 8'd0};
         4'd11:   c = '{8'd255, 8'd128, 8'd0};
         4'd12:   c = '{8'd128, 8'd255, 8'd255};
         4'd13:   c = '{8'd128, 8'd0,   8'd255};
         default: c = '{8'd0,   8'd0,   8'd0};
      endcase
      return c;
   endfunction

endpackage

// File: sv/rpf_if.sv
// ----------------------------------------------------------------------------
// rpf_if
// Valid/ready channels of the palette fader: request and response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rpf_req_if;
   import rpf_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [REQ_TYPE_W-1:0]   req_type;
   logic [RAND_PICK_W-1:0]  rand_pick;
   logic [RAND_DELAY_W-1:0] rand_delay;

   modport source(output valid, req_type, rand_pick, rand_delay, input ready);
   modport sink(input valid, req_type, rand_pick, rand_delay, output ready);
endinterface

interface rpf_rsp_if;
   import rpf_pkg::*;
   logic               valid;
   logic               ready;
   logic [RGB_W-1:0]   red_out;
   logic [RGB_W-1:0]   green_out;
   logic [RGB_W-1:0]   blue_out;
   logic [DELAY_W-1:0] delay_ms;
   logic               running;

   modport source(output valid, red_out, green_out, blue_out, delay_ms, running,
                  input ready);
   modport sink(input valid, red_out, green_out, blue_out, delay_ms, running,
                output ready);
endinterface

// File: sv/rpf_ctrl.sv
// ----------------------------------------------------------------------------
// rpf_ctrl
// Sequencer of the palette fader: walks one transaction through prepare,
// target check, draw (divide and scan), step and response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rgb_palette_fader_defines.svh"

module rpf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rpf_pkg::rpf_status_type status,
   output rpf_pkg::rpf_cmd_type   cmd
);
   import rpf_pkg::*;

   rpf_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = status.do_tick ? S_CHECK : S_DONE;
         end
         S_CHECK: begin
            if (status.at_target) begin
               state_in = S_LOAD;
            end else begin
               cmd.step = 1'b1;
               state_in = S_DONE;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_hit) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `RPF_ASSERT_NEXT(a_accept_to_prep, req_valid && req_ready, state_ff == S_PREP, "accept not followed by prepare")
   `RPF_ASSERT_SAME(a_scan_after_div, state_ff == S_SCAN, $past(state_ff) == S_DIV || $past(state_ff) == S_SCAN, "scan entered without divide")
   `RPF_ASSERT_NEXT(a_done_holds_rsp, state_ff == S_DONE && rsp_valid_ff && !rsp_ready, state_ff == S_DONE && rsp_valid_ff, "response overwritten while stalled")

endmodule

// File: sv/rpf_dp.sv
// ----------------------------------------------------------------------------
// rpf_dp
// Datapath of the palette fader: color and target registers, bag mask,
// bit-serial dividers for pick index and tick delay, palette scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rgb_palette_fader_defines.svh"

module rpf_dp #(
   parameter int PALETTE_SIZE = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rpf_pkg::SPEED_W-1:0]         csr_wdata,
   input  logic [rpf_pkg::REQ_TYPE_W-1:0]      req_type,
   input  logic [rpf_pkg::RAND_PICK_W-1:0]     rand_pick,
   input  logic [rpf_pkg::RAND_DELAY_W-1:0]    rand_delay,
   input  rpf_pkg::rpf_cmd_type                cmd,
   output rpf_pkg::rpf_status_type             status,
   output logic [rpf_pkg::RGB_W-1:0]           red_out,
   output logic [rpf_pkg::RGB_W-1:0]           green_out,
   output logic [rpf_pkg::RGB_W-1:0]           blue_out,
   output logic [rpf_pkg::DELAY_W-1:0]         delay_ms,
   output logic                                running
);
   import rpf_pkg::*;

   localparam int MW = PALETTE_SIZE;
   localparam int CW = $clog2(PALETTE_SIZE + 1);
   localparam int IW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
   localparam logic [MW-1:0] FULL_MASK = '1;

   // architectural state
   rgb_type             cur_ff, cur_in;
   rgb_type             tgt_ff, tgt_in;
   logic [MW-1:0]       mask_ff, mask_in;
   logic [DELAY_W-1:0]  delay_ff, delay_in;
   logic                enabled_ff, enabled_in;
   logic [SPEED_W-1:0]  speed_ff, speed_in;

   // transaction and working registers
   logic [REQ_TYPE_W-1:0]   req_type_ff, req_type_in;
   logic [RAND_PICK_W-1:0]  rand_pick_ff, rand_pick_in;
   logic [RAND_DELAY_W-1:0] rand_delay_ff, rand_delay_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           pr_ff, pr_in;
   logic [RAND_PICK_W-1:0]  pq_ff, pq_in;
   logic [DVS_W-1:0]        dvs_ff, dvs_in;
   logic [DVS_W-1:0]        dr_ff, dr_in;
   logic [RAND_PICK_W-1:0]  dq_ff, dq_in;
   logic [DIV_CNT_W-1:0]    st_ff, st_in;
   logic [IW-1:0]           i_ff, i_in;
   logic [CW-1:0]           k_ff, k_in;

   // output register
   rgb_type             out_rgb_ff, out_rgb_in;
   logic [DELAY_W-1:0]  out_delay_ff, out_delay_in;
   logic                out_run_ff, out_run_in;

   logic [MW-1:0]  norm_mask;
   logic [CW-1:0]  norm_count;
   logic [CW:0]    p_trial;
   logic           p_ge;
   logic [DVS_W:0] d_trial;
   logic           d_ge;
   logic           scan_bit;
   logic           scan_hit;

   assign norm_mask = ((mask_ff & FULL_MASK) == '0) ? FULL_MASK : mask_ff;

   always_comb begin
      norm_count = '0;
      for (int j = 0; j < MW; j++) begin
         norm_count = norm_count + CW'(norm_mask[j]);
      end
   end

   assign p_trial  = {pr_ff, pq_ff[RAND_PICK_W-1]};
   assign p_ge     = p_trial >= {1'b0, count_ff};
   assign d_trial  = {dr_ff, dq_ff[RAND_PICK_W-1]};
   assign d_ge     = d_trial >= {1'b0, dvs_ff};
   assign scan_bit = mask_ff[i_ff];
   assign scan_hit = scan_bit && (k_ff == pr_ff);

   assign status.do_tick   = (req_type_ff == REQ_TICK) || (req_type_ff == REQ_START);
   assign status.at_target = (cur_ff == tgt_ff);
   assign status.div_last  = (st_ff == DIV_LAST);
   assign status.scan_hit  = scan_hit;

   function automatic logic [RGB_W-1:0] step_to(input logic [RGB_W-1:0] c,
                                                input logic [RGB_W-1:0] t);
      logic [RGB_W-1:0] r;
      if (c > t) begin
         r = c - RGB_W'(1);
      end else if (c < t) begin
         r = c + RGB_W'(1);
      end else begin
         r = c;
      end
      return r;
   endfunction

   always_comb begin
      cur_in        = cur_ff;
      tgt_in        = tgt_ff;
      mask_in       = mask_ff;
      delay_in      = delay_ff;
      enabled_in    = enabled_ff;
      speed_in      = csr_we ? csr_wdata : speed_ff;
      req_type_in   = req_type_ff;
      rand_pick_in  = rand_pick_ff;
      rand_delay_in = rand_delay_ff;
      count_in      = count_ff;
      pr_in         = pr_ff;
      pq_in         = pq_ff;
      dvs_in        = dvs_ff;
      dr_in         = dr_ff;
      dq_in         = dq_ff;
      st_in         = st_ff;
      i_in          = i_ff;
      k_in          = k_ff;
      out_rgb_in    = out_rgb_ff;
      out_delay_in  = out_delay_ff;
      out_run_in    = out_run_ff;

      if (cmd.latch) begin
         req_type_in   = req_type;
         rand_pick_in  = rand_pick;
         rand_delay_in = rand_delay;
      end

      if (cmd.prep) begin
         case (req_type_ff)
            REQ_START: begin
               enabled_in = 1'b1;
               cur_in     = '0;
               mask_in    = '0;
            end
            REQ_STOP: enabled_in = 1'b0;
            default:  ;
         endcase
      end

      if (cmd.load) begin
         mask_in  = norm_mask;
         count_in = norm_count;
         pr_in    = '0;
         pq_in    = rand_pick_ff;
         dvs_in   = DVS_W'(speed_ff) + DVS_W'(rand_delay_ff) + DVS_W'(1);
         dr_in    = '0;
         dq_in    = DELAY_NUM;
         st_in    = '0;
         i_in     = '0;
         k_in     = '0;
      end

      if (cmd.div_step) begin
         pr_in = p_ge ? CW'(p_trial - {1'b0, count_ff}) : CW'(p_trial);
         pq_in = {pq_ff[RAND_PICK_W-2:0], 1'b0};
         dr_in = d_ge ? DVS_W'(d_trial - {1'b0, dvs_ff}) : DVS_W'(d_trial);
         dq_in = {dq_ff[RAND_PICK_W-2:0], d_ge};
         st_in = st_ff + DIV_CNT_W'(1);
         if (status.div_last) begin
            delay_in = dq_in[DELAY_W-1:0];
         end
      end

      if (cmd.scan) begin
         if (scan_hit) begin
            mask_in = mask_ff & ~(MW'(1) << i_ff);
            tgt_in  = pal_color(PAL_IDX_W'(i_ff));
         end else begin
            i_in = i_ff + IW'(1);
            if (scan_bit) begin
               k_in = k_ff + CW'(1);
            end
         end
      end

      // a draw ends in the step as well
      if (cmd.step || (cmd.scan && scan_hit)) begin
         cur_in.red   = step_to(cur_ff.red,   tgt_in.red);
         cur_in.green = step_to(cur_ff.green, tgt_in.green);
         cur_in.blue  = step_to(cur_ff.blue,  tgt_in.blue);
      end

      if (cmd.out_load) begin
         out_rgb_in   = cur_ff;
         out_delay_in = delay_ff;
         out_run_in   = enabled_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff     <= '0;
         tgt_ff     <= '0;
         mask_ff    <= '0;
         delay_ff   <= DELAY_RESET;
         enabled_ff <= 1'b0;
         speed_ff   <= '0;
      end else begin
         cur_ff     <= cur_in;
         tgt_ff     <= tgt_in;
         mask_ff    <= mask_in;
         delay_ff   <= delay_in;
         enabled_ff <= enabled_in;
         speed_ff   <= speed_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff   <= req_type_in;
      rand_pick_ff  <= rand_pick_in;
      rand_delay_ff <= rand_delay_in;
      count_ff      <= count_in;
      pr_ff         <= pr_in;
      pq_ff         <= pq_in;
      dvs_ff        <= dvs_in;
      dr_ff         <= dr_in;
      dq_ff         <= dq_in;
      st_ff         <= st_in;
      i_ff          <= i_in;
      k_ff          <= k_in;
      out_rgb_ff    <= out_rgb_in;
      out_delay_ff  <= out_delay_in;
      out_run_ff    <= out_run_in;
   end

   assign red_out   = out_rgb_ff.red;
   assign green_out = out_rgb_ff.green;
   assign blue_out  = out_rgb_ff.blue;
   assign delay_ms  = out_delay_ff;
   assign running   = out_run_ff;

   `RPF_ASSERT_SAME(a_scan_mask_nonempty, cmd.scan, mask_ff != '0, "scan over empty bag")
   `RPF_ASSERT_SAME(a_scan_index_in_range, cmd.scan, pr_ff < count_ff, "pick index not below count")
   `RPF_ASSERT_NEXT(a_hit_takes_one, cmd.scan && scan_hit, $countones(mask_ff) + 1 == $countones($past(mask_ff)), "draw did not remove exactly one entry")

endmodule

// File: sv/rgb_palette_fader.sv
// ----------------------------------------------------------------------------
// rgb_palette_fader
// From accept to response valid, stop or unused code goes from prepare
// straight to the response, a plain tick goes prepare, check, step, and a
// tick that draws a new target goes prepare, check, load, the 16-step serial
// divider and the one-entry-per-cycle scan. One transaction in flight; the
// next is taken the cycle after the result is registered; it may still wait.
// Synchronous reset: black color and target, empty bag, 1000 ms, stopped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_palette_fader #(
   parameter int PALETTE_SIZE = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   rpf_req_if.sink                       req_chan,
   rpf_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [rpf_pkg::SPEED_W-1:0]   csr_wdata
);
   import rpf_pkg::*;

   rpf_cmd_type    cmd;
   rpf_status_type status;

   rpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rpf_dp #(
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_type   (req_chan.req_type),
      .rand_pick  (req_chan.rand_pick),
      .rand_delay (req_chan.rand_delay),
      .cmd        (cmd),
      .status     (status),
      .red_out    (rsp_chan.red_out),
      .green_out  (rsp_chan.green_out),
      .blue_out   (rsp_chan.blue_out),
      .delay_ms   (rsp_chan.delay_ms),
      .running    (rsp_chan.running)
   );

endmodule
